// ----- hdl/bxf_pkg.sv -----
// Shared types and constants of the box filter mean block.
package bxf_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 14;
    localparam int POS_W    = 13;
    localparam int COLSUM_W = 14;
    localparam int WINSUM_W = 20;
    localparam int MEAN_MAX = 255;

    localparam int CFG_WIDTH_RST  = 5716;
    localparam int CFG_HEIGHT_RST = 3731;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CREDIT_W   = 4;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_coord;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        t_coord           coord;
    } t_result;

    typedef struct packed {
        logic                valid;
        logic [WINSUM_W-1:0] sum;
        t_coord              coord;
    } t_mean_req;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_mean_rsp;

endpackage

// ----- hdl/bxf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module bxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bxf_mean.sv -----
// Two-stage divide of the window sum by the window area through a reciprocal.
module bxf_mean #(
    parameter int WINDOW = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bxf_pkg::t_mean_req i_req,
    output bxf_pkg::t_mean_rsp o_rsp
);

    localparam int SUM_W   = bxf_pkg::WINSUM_W;
    localparam int AREA    = WINDOW * WINDOW;
    localparam int RECIP   = (1 << SUM_W) / AREA;
    localparam int RECIP_W = $clog2(RECIP + 1);

    logic [SUM_W+RECIP_W-1:0] prod;
    logic [RECIP_W-1:0]       q_est;

    logic                 r_a_valid;
    logic [RECIP_W-1:0]   r_a_q;
    logic [SUM_W-1:0]     r_a_sum;
    bxf_pkg::t_coord      r_a_coord;

    logic [SUM_W-1:0]     q_area;
    logic [SUM_W-1:0]     rem;
    logic [RECIP_W:0]     q_fix;
    logic [bxf_pkg::PIX_W-1:0] mean;

    bxf_pkg::t_mean_rsp   r_rsp;

    // Estimate may fall one short of the true quotient.
    assign prod  = (SUM_W+RECIP_W)'(i_req.sum) * (SUM_W+RECIP_W)'(RECIP);
    assign q_est = prod[SUM_W+RECIP_W-1:SUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
        end
        r_a_q     <= q_est;
        r_a_sum   <= i_req.sum;
        r_a_coord <= i_req.coord;
    end

    assign q_area = SUM_W'(SUM_W'(r_a_q) * SUM_W'(AREA));
    assign rem    = r_a_sum - q_area;
    assign q_fix  = {1'b0, r_a_q} + (RECIP_W+1)'(rem >= SUM_W'(AREA));
    assign mean   = (q_fix > (RECIP_W+1)'(bxf_pkg::MEAN_MAX))
                    ? bxf_pkg::PIX_W'(bxf_pkg::MEAN_MAX) : q_fix[bxf_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp.valid <= 1'b0;
        end else begin
            r_rsp.valid <= r_a_valid;
        end
        r_rsp.data.mean  <= mean;
        r_rsp.data.coord <= r_a_coord;
    end

    assign o_rsp = r_rsp;

endmodule

// ----- hdl/box_filter_mean.sv -----
// Box filter mean: streaming WINDOW x WINDOW average over a raster pixel stream.
//
// Takes one pixel per clock while o_ready is high and gives one mean per window
// whose bottom-right corner is the pixel just taken (the last row and column of
// the frame never close a window). Column sums live in a MAX_WIDTH-deep RAM that
// is read and rewritten for every pixel, with a bypass for the column written
// the cycle before; the last WINDOW rows live in a WINDOW*MAX_WIDTH row RAM.
// Neither RAM is cleared: the first WINDOW rows of a frame rebuild their
// contents. Results wait in an eight-entry output queue; o_ready drops only when
// eight results are queued or still in flight, so the input keeps flowing while
// a result waits. Image width and height are written through i_cfg_*; the user
// must do so only while the block is idle, which the block does not enforce.
// Zero acts as one and values above MAX_WIDTH/MAX_HEIGHT are clamped.
module box_filter_mean #(
    parameter int WINDOW     = 50,
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bxf_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_frame_start,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bxf_pkg::PIX_W-1:0]       o_mean_value,
    output logic [bxf_pkg::POS_W-1:0]       o_out_col,
    output logic [bxf_pkg::POS_W-1:0]       o_out_row,
    input  logic                            i_cfg_we,
    input  logic [bxf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bxf_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SW    = $clog2(WINDOW);
    localparam int RS_AW = $clog2(WINDOW * MAX_WIDTH);
    localparam int CS_W  = bxf_pkg::COLSUM_W;
    localparam int WS_W  = bxf_pkg::WINSUM_W;
    localparam int POS_W = bxf_pkg::POS_W;

    localparam int W_RST_M1 = (bxf_pkg::CFG_WIDTH_RST > MAX_WIDTH)
                              ? MAX_WIDTH - 1 : bxf_pkg::CFG_WIDTH_RST - 1;
    localparam int H_RST_M1 = (bxf_pkg::CFG_HEIGHT_RST > MAX_HEIGHT)
                              ? MAX_HEIGHT - 1 : bxf_pkg::CFG_HEIGHT_RST - 1;

    // Configuration, held as effective size minus one
    logic [CW-1:0] r_w_m1;
    logic [RW-1:0] r_h_m1;

    // Raster position
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [SW-1:0]    r_slot, n_slot;
    logic [RS_AW-1:0] r_base, n_base;

    logic             accept;
    logic [CW-1:0]    cur_col;
    logic [RW-1:0]    cur_row;
    logic [SW-1:0]    cur_slot;
    logic [RS_AW-1:0] cur_base;
    logic             cur_emit;
    logic [RS_AW-1:0] cur_rs_addr;

    // Stage 1: RAM data returns, column sum update
    logic                        r_s1_valid;
    logic [bxf_pkg::PIX_W-1:0]   r_s1_pixel;
    logic [CW-1:0]               r_s1_col;
    logic [RS_AW-1:0]            r_s1_rs_addr;
    logic                        r_s1_row_zero;
    logic                        r_s1_sub_old;
    logic                        r_s1_col_zero;
    logic                        r_s1_col_full;
    logic                        r_s1_emit;
    bxf_pkg::t_coord             r_s1_coord;
    logic                        r_s1_fwd_hit;
    logic [CS_W-1:0]             r_s1_fwd_data;

    logic [CS_W-1:0]             cs_rdata;
    logic [bxf_pkg::PIX_W-1:0]   rs_rdata;
    logic [CS_W-1:0]             colsum_old;
    logic [CS_W-1:0]             n_cs;

    // Stage 2: horizontal window sum
    logic                        r_s2_valid;
    logic [CS_W-1:0]             r_s2_cs;
    logic                        r_s2_col_zero;
    logic                        r_s2_col_full;
    logic                        r_s2_emit;
    bxf_pkg::t_coord             r_s2_coord;

    logic [CS_W-1:0]             r_taps [WINDOW];
    logic [WS_W-1:0]             r_window_sum, n_window_sum;
    bxf_pkg::t_mean_req          r_s3_req;
    bxf_pkg::t_mean_rsp          mean_rsp;

    // Output queue
    bxf_pkg::t_result                 r_fifo [bxf_pkg::FIFO_DEPTH];
    logic [bxf_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [bxf_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [bxf_pkg::CREDIT_W-1:0]     r_fifo_cnt;
    logic [bxf_pkg::CREDIT_W-1:0]     r_credit;
    logic                             pop;
    logic                             push;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= CW'(W_RST_M1);
            r_h_m1 <= RW'(H_RST_M1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bxf_pkg::CFG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w_m1 <= '0;
                    end else if (i_cfg_data > bxf_pkg::CFG_W'(MAX_WIDTH)) begin
                        r_w_m1 <= CW'(MAX_WIDTH - 1);
                    end else begin
                        r_w_m1 <= CW'(i_cfg_data - bxf_pkg::CFG_W'(1));
                    end
                end
                bxf_pkg::CFG_IMAGE_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h_m1 <= '0;
                    end else if (i_cfg_data > bxf_pkg::CFG_W'(MAX_HEIGHT)) begin
                        r_h_m1 <= RW'(MAX_HEIGHT - 1);
                    end else begin
                        r_h_m1 <= RW'(i_cfg_data - bxf_pkg::CFG_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Frame start restarts the raster position at once
    assign cur_col  = i_frame_start ? '0 : r_col;
    assign cur_row  = i_frame_start ? '0 : r_row;
    assign cur_slot = i_frame_start ? '0 : r_slot;
    assign cur_base = i_frame_start ? '0 : r_base;

    assign cur_rs_addr = cur_base + RS_AW'(cur_col);
    assign cur_emit    = (cur_row >= RW'(WINDOW - 1)) && (cur_col >= CW'(WINDOW - 1))
                         && (cur_row < r_h_m1) && (cur_col < r_w_m1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        n_base = r_base;
        if (accept) begin
            if (cur_col >= r_w_m1) begin
                n_col = '0;
                if (cur_row >= r_h_m1) begin
                    n_row  = '0;
                    n_slot = '0;
                    n_base = '0;
                end else begin
                    n_row = cur_row + RW'(1);
                    if (cur_slot == SW'(WINDOW - 1)) begin
                        n_slot = '0;
                        n_base = '0;
                    end else begin
                        n_slot = cur_slot + SW'(1);
                        n_base = cur_base + RS_AW'(MAX_WIDTH);
                    end
                end
            end else begin
                n_col  = cur_col + CW'(1);
                n_row  = cur_row;
                n_slot = cur_slot;
                n_base = cur_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_base <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_pixel     <= i_pixel;
        r_s1_col       <= cur_col;
        r_s1_rs_addr   <= cur_rs_addr;
        r_s1_row_zero  <= (cur_row == '0);
        r_s1_sub_old   <= (cur_row >= RW'(WINDOW));
        r_s1_col_zero  <= (cur_col == '0);
        r_s1_col_full  <= (cur_col >= CW'(WINDOW));
        r_s1_emit      <= cur_emit;
        r_s1_coord.col <= POS_W'(cur_col) - POS_W'(WINDOW - 1);
        r_s1_coord.row <= POS_W'(cur_row) - POS_W'(WINDOW - 1);
        // Bypass the column sum written at this same edge
        r_s1_fwd_hit   <= r_s1_valid && (r_s1_col == cur_col);
        r_s1_fwd_data  <= n_cs;
    end

    bxf_ram #(
        .WIDTH (CS_W),
        .DEPTH (MAX_WIDTH)
    ) u_colsum_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (n_cs),
        .i_raddr (cur_col),
        .o_rdata (cs_rdata)
    );

    bxf_ram #(
        .WIDTH (bxf_pkg::PIX_W),
        .DEPTH (WINDOW * MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_rs_addr),
        .i_wdata (r_s1_pixel),
        .i_raddr (cur_rs_addr),
        .o_rdata (rs_rdata)
    );

    assign colsum_old = r_s1_fwd_hit ? r_s1_fwd_data : cs_rdata;

    always_comb begin
        if (r_s1_row_zero) begin
            n_cs = CS_W'(r_s1_pixel);
        end else begin
            n_cs = colsum_old + CS_W'(r_s1_pixel)
                   - (r_s1_sub_old ? CS_W'(rs_rdata) : CS_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_cs       <= n_cs;
        r_s2_col_zero <= r_s1_col_zero;
        r_s2_col_full <= r_s1_col_full;
        r_s2_emit     <= r_s1_emit;
        r_s2_coord    <= r_s1_coord;
    end

    // Oldest tap holds the column sum from WINDOW columns back in this row
    always_comb begin
        if (r_s2_col_zero) begin
            n_window_sum = WS_W'(r_s2_cs);
        end else begin
            n_window_sum = r_window_sum + WS_W'(r_s2_cs)
                           - (r_s2_col_full ? WS_W'(r_taps[WINDOW-1]) : WS_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_taps[0] <= r_s2_cs;
            for (int i = 1; i < WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_sum   <= '0;
            r_s3_req.valid <= 1'b0;
        end else begin
            if (r_s2_valid) begin
                r_window_sum <= n_window_sum;
            end
            r_s3_req.valid <= r_s2_valid && r_s2_emit;
        end
        r_s3_req.sum   <= n_window_sum;
        r_s3_req.coord <= r_s2_coord;
    end

    bxf_mean #(
        .WINDOW (WINDOW)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_s3_req),
        .o_rsp   (mean_rsp)
    );

    assign push = mean_rsp.valid;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= mean_rsp.data;
        end
    end

    // Count results in flight plus queued; hold input when the queue could overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + bxf_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + bxf_pkg::FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + bxf_pkg::CREDIT_W'(push) - bxf_pkg::CREDIT_W'(pop);
            r_credit   <= r_credit + bxf_pkg::CREDIT_W'(accept && cur_emit)
                          - bxf_pkg::CREDIT_W'(pop);
        end
    end

    assign o_ready      = (r_credit < bxf_pkg::CREDIT_W'(bxf_pkg::FIFO_DEPTH));
    assign o_valid      = (r_fifo_cnt != '0);
    assign o_mean_value = r_fifo[r_rd_ptr].mean;
    assign o_out_col    = r_fifo[r_rd_ptr].coord.col;
    assign o_out_row    = r_fifo[r_rd_ptr].coord.row;

endmodule
